@@ rtl/core/mts_pkg.sv @@
package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       entry_count;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] run_min;
  } entry_t;

endpackage

@@ rtl/core/min_tracking_stack_core.sv @@
// min tracking stack: a bounded lifo of signed 32-bit words that also reports
// the minimum of everything held.
// input channel in_valid/in_stall/in_data carries a push or a pop command;
// every accepted transaction yields exactly one result on out_valid/out_stall/
// out_data with popped value, new top, new minimum, empty, overflow and count.
// the top entry lives in a register, the entries below it in one synchronous
// memory of value/minimum pairs. a push, a pop that empties the stack or leaves
// it empty, and a dropped push register their result at once; a pop that leaves
// one or more entries first needs the memory read of the new top. no new
// transaction is taken while that read is pending, so pushes sustain 1 item per
// cycle while out_stall stays low, and a deep pop blocks the input until done.
// a result sits in the output register until the receiver drops out_stall; a
// new transaction is accepted while the held result is taken in the same cycle.
// synchronous reset (rst_n low) empties the stack and clears the output valid;
// the memory contents are not cleared, no clearing pass is needed.
module min_tracking_stack_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mts_pkg::out_item_t out_data
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_POP_RD = 1'b1;

  logic                                state_r, state_nxt;
  logic [mts_pkg::PTR_W-1:0]           sp_r, sp_nxt;
  logic signed [mts_pkg::DATA_W-1:0]   top_val_r, top_val_nxt;
  logic signed [mts_pkg::DATA_W-1:0]   top_min_r, top_min_nxt;
  logic signed [mts_pkg::DATA_W-1:0]   pop_val_r, pop_val_nxt;
  logic                                out_valid_r, out_valid_nxt;
  mts_pkg::out_item_t                  out_data_r, out_data_nxt;

  mts_pkg::entry_t                     mem [mts_pkg::STACK_DEPTH];
  mts_pkg::entry_t                     rd_data_r;
  logic                                wr_en, rd_en;
  logic [mts_pkg::ADDR_W-1:0]          wr_addr, rd_addr;
  mts_pkg::entry_t                     wr_data;

  logic                                accept;
  logic                                full, empty;
  logic [mts_pkg::PTR_W-1:0]           sp_minus2;
  logic signed [mts_pkg::DATA_W-1:0]   new_min;
  logic [mts_pkg::PTR_W+mts_pkg::COUNT_W-1:0] count_ext;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign full      = (sp_r == mts_pkg::PTR_W'(mts_pkg::STACK_DEPTH));
  assign empty     = (sp_r == '0);
  assign sp_minus2 = sp_r - mts_pkg::PTR_W'(2);
  assign new_min   = (!empty && (top_min_r < in_data.push_value)) ? top_min_r
                                                                 : in_data.push_value;
  assign count_ext = {{mts_pkg::COUNT_W{1'b0}}, sp_nxt};

  // pushes that fit land in memory too, so deep pops can fetch the entry below
  assign wr_en        = accept && (in_data.command == mts_pkg::CMD_PUSH) && !full;
  assign wr_addr      = sp_r[mts_pkg::ADDR_W-1:0];
  assign wr_data      = '{value: in_data.push_value, run_min: new_min};
  assign rd_en        = accept && (in_data.command == mts_pkg::CMD_POP) &&
                        (sp_r > mts_pkg::PTR_W'(1));
  assign rd_addr      = sp_minus2[mts_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    top_val_nxt   = top_val_r;
    top_min_nxt   = top_min_r;
    pop_val_nxt   = pop_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.popped_value = mts_pkg::EMPTY_WORD;
          out_data_nxt.overflow     = 1'b0;
          if (in_data.command == mts_pkg::CMD_PUSH) begin
            if (full) begin
              out_data_nxt.overflow = 1'b1;
            end else begin
              sp_nxt      = sp_r + mts_pkg::PTR_W'(1);
              top_val_nxt = in_data.push_value;
              top_min_nxt = new_min;
            end
          end else if (!empty) begin
            sp_nxt                    = sp_r - mts_pkg::PTR_W'(1);
            out_data_nxt.popped_value = top_val_r;
          end
          out_data_nxt.entry_count = count_ext[mts_pkg::COUNT_W-1:0];
          out_data_nxt.is_empty    = (sp_nxt == '0);
          if (rd_en) begin
            // new top comes from memory next cycle
            pop_val_nxt = top_val_r;
            state_nxt   = ST_POP_RD;
          end else begin
            out_valid_nxt = 1'b1;
            if (sp_nxt == '0) begin
              out_data_nxt.top_value = mts_pkg::EMPTY_WORD;
              out_data_nxt.min_value = mts_pkg::EMPTY_WORD;
            end else begin
              out_data_nxt.top_value = top_val_nxt;
              out_data_nxt.min_value = top_min_nxt;
            end
          end
        end
      end
      ST_POP_RD: begin
        top_val_nxt               = rd_data_r.value;
        top_min_nxt               = rd_data_r.run_min;
        out_data_nxt.popped_value = pop_val_r;
        out_data_nxt.top_value    = rd_data_r.value;
        out_data_nxt.min_value    = rd_data_r.run_min;
        out_valid_nxt             = 1'b1;
        state_nxt                 = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r  <= top_val_nxt;
    top_min_r  <= top_min_nxt;
    pop_val_r  <= pop_val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_RD) |-> !out_valid_r)
    else $error("result valid while memory read pending");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_RD) |=> (state_r == ST_IDLE))
    else $error("pop read state held longer than one cycle");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= mts_pkg::PTR_W'(mts_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (sp_r == '0)))
    else $error("empty flag disagrees with stack pointer");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overflow) |->
      (sp_r == mts_pkg::PTR_W'(mts_pkg::STACK_DEPTH)))
    else $error("overflow reported while not full");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mts_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mts_pkg::out_item_t  out_data;

  // mirror of the stack contents, updated when a transaction is accepted
  logic signed [mts_pkg::DATA_W-1:0] stack_vals [mts_pkg::STACK_DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] stack_mins [mts_pkg::STACK_DEPTH];
  int unsigned                       stack_height = 0;

  mts_pkg::out_item_t pending_results [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  bit                 tx_idle_en = 1'b1;
  bit                 rx_idle_en = 1'b1;
  int                 hold_seq = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  min_tracking_stack_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mts_pkg::out_item_t apply_stack_op(input mts_pkg::in_item_t item);
    mts_pkg::out_item_t                r;
    logic signed [mts_pkg::DATA_W-1:0] run_min;
    r.popped_value = mts_pkg::EMPTY_WORD;
    r.overflow     = 1'b0;
    if (item.command == mts_pkg::CMD_PUSH) begin
      if (stack_height >= mts_pkg::STACK_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        run_min = item.push_value;
        if (stack_height > 0 &&
            $signed(stack_mins[stack_height-1]) < $signed(item.push_value)) begin
          run_min = stack_mins[stack_height-1];
        end
        stack_vals[stack_height] = item.push_value;
        stack_mins[stack_height] = run_min;
        stack_height++;
      end
    end else if (stack_height > 0) begin
      stack_height--;
      r.popped_value = stack_vals[stack_height];
    end
    r.top_value   = (stack_height > 0) ? stack_vals[stack_height-1] : mts_pkg::EMPTY_WORD;
    r.min_value   = (stack_height > 0) ? stack_mins[stack_height-1] : mts_pkg::EMPTY_WORD;
    r.is_empty    = (stack_height == 0);
    r.entry_count = mts_pkg::COUNT_W'(stack_height);
    return r;
  endfunction

  // push values lean on the corners and on ties with the current minimum
  function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return mts_pkg::EMPTY_WORD;
      3: return '0;
      4, 5: return $signed($urandom_range(0, 20)) - 10;
      6: return (stack_height > 0) ? stack_mins[stack_height-1] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic mts_pkg::in_item_t make_item(input logic cmd,
                                                  input logic signed [mts_pkg::DATA_W-1:0] v);
    mts_pkg::in_item_t it;
    it.command    = cmd;
    it.push_value = v;
    return it;
  endfunction

  task automatic send_item(input mts_pkg::in_item_t item);
    while (tx_idle_en && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_stack_op(item));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [mts_pkg::DATA_W-1:0] exp_v,
                             input logic [mts_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < 28);
    end
  end

  always @(posedge clk) begin
    mts_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction on output: %h", $time, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("popped_value", exp_r.popped_value, out_data.popped_value);
        check_field("top_value", exp_r.top_value, out_data.top_value);
        check_field("min_value", exp_r.min_value, out_data.min_value);
        check_field("is_empty", mts_pkg::DATA_W'(exp_r.is_empty),
                    mts_pkg::DATA_W'(out_data.is_empty));
        check_field("overflow", mts_pkg::DATA_W'(exp_r.overflow),
                    mts_pkg::DATA_W'(out_data.overflow));
        check_field("entry_count", mts_pkg::DATA_W'(exp_r.entry_count),
                    mts_pkg::DATA_W'(out_data.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_item(mts_pkg::CMD_POP, 32'sh7fff_ffff));     // pop on empty
    send_item(make_item(mts_pkg::CMD_POP, 32'sh8000_0000));
    send_item(make_item(mts_pkg::CMD_PUSH, '0));
    send_item(make_item(mts_pkg::CMD_PUSH, mts_pkg::EMPTY_WORD)); // held -1 while not empty
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh7fff_ffff));
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh8000_0000));
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh8000_0000));     // tie with current min
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sd5));
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh8000_0001));
    repeat (7) send_item(make_item(mts_pkg::CMD_POP, $urandom));
    send_item(make_item(mts_pkg::CMD_POP, mts_pkg::EMPTY_WORD));
    send_item(make_item(mts_pkg::CMD_PUSH, mts_pkg::EMPTY_WORD));
    send_item(make_item(mts_pkg::CMD_POP, '0));                  // pops a -1 and empties
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh1234_5678));
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh1234_5678));
    send_item(make_item(mts_pkg::CMD_POP, 32'sh5555_aaaa));
    send_item(make_item(mts_pkg::CMD_POP, 32'shaaaa_5555));
    drain_results();
  endtask

  task automatic test_random_mix();
    int push_pct;
    for (int i = 0; i < 200; i++) begin
      // alternate growing and shrinking phases so the depth wanders
      push_pct = ((i / 50) % 2 == 0) ? 70 : 35;
      if ($urandom_range(0, 99) < push_pct) begin
        send_item(make_item(mts_pkg::CMD_PUSH, pick_value()));
      end else begin
        send_item(make_item(mts_pkg::CMD_POP, $urandom));
      end
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 99) < 60) begin
        send_item(make_item(mts_pkg::CMD_PUSH, pick_value()));
      end else begin
        send_item(make_item(mts_pkg::CMD_POP, $urandom));
      end
    end
    drain_results();
  endtask

  task automatic test_fill_and_overflow();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (stack_height < mts_pkg::STACK_DEPTH) begin
      send_item(make_item(mts_pkg::CMD_PUSH, pick_value()));
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (5) send_item(make_item(mts_pkg::CMD_PUSH, pick_value()));
    send_item(make_item(mts_pkg::CMD_POP, $urandom));
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh8000_0000));   // refill the last slot
    send_item(make_item(mts_pkg::CMD_PUSH, 32'sh7fff_ffff));   // dropped again
    repeat (32) send_item(make_item(mts_pkg::CMD_POP, $urandom));
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_backpressure();
    test_fill_and_overflow();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
